FILE: src/csa_pkg.sv
// Package for the compacting slot array: sizes, opcodes, status codes and
// the command struct broadcast from the control logic to the slot cells.
// No dependencies.
`default_nettype none

package csa_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ELEM_BITS   = 32;
  localparam int COUNT_W     = 7;
  localparam int INDEX_W     = 8;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_RESIZE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 2'd3;

  localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] ENTRY_LIMIT     = COUNT_W'(MAX_ENTRIES);

  localparam logic [ELEM_BITS-1:0] SLOT_ONES = {ELEM_BITS{1'b1}};

  localparam int REG_MAX_COUNT = 0;

  typedef struct packed {
    logic                 ok;
    logic [OP_W-1:0]      op;
    logic [INDEX_W-1:0]   idx;
    logic [COUNT_W-1:0]   nlen;
    logic [COUNT_W-1:0]   live;
    logic [ELEM_BITS-1:0] wval;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: src/csa_cell.sv
// One slot cell of the compacting slot array: holds one slot and updates it
// from the broadcast command and its upper neighbor. Depends on csa_pkg.
`default_nettype none

module csa_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [csa_pkg::COUNT_W-1:0]    cell_id,
  input  wire csa_pkg::cell_cmd_t             cmd,
  input  wire logic [csa_pkg::ELEM_BITS-1:0]  up_slot,
  output logic      [csa_pkg::ELEM_BITS-1:0]  slot,
  output logic      [csa_pkg::ELEM_BITS-1:0]  rd_part
);

  logic [csa_pkg::ELEM_BITS-1:0] slot_r;
  logic [csa_pkg::ELEM_BITS-1:0] slot_nxt;
  logic [csa_pkg::INDEX_W-1:0]   id_ext;
  logic [csa_pkg::INDEX_W-1:0]   id_plus1;
  logic [csa_pkg::INDEX_W-1:0]   live_ext;

  assign id_ext   = {1'b0, cell_id};
  assign id_plus1 = id_ext + 8'd1;
  assign live_ext = {1'b0, cmd.live};
  assign slot     = slot_r;
  assign rd_part  = (id_ext == cmd.idx) ? slot_r : '0;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.ok) begin
      unique case (cmd.op)
        csa_pkg::OP_CLEAR: begin
          slot_nxt = csa_pkg::SLOT_ONES;
        end
        csa_pkg::OP_APPEND: begin
          if (cell_id == cmd.live) slot_nxt = '0;
        end
        csa_pkg::OP_REMOVE: begin
          if (id_ext >= cmd.idx && id_plus1 < live_ext) slot_nxt = up_slot;
          else if (id_plus1 == live_ext) slot_nxt = csa_pkg::SLOT_ONES;
        end
        csa_pkg::OP_RESIZE: begin
          if (cmd.nlen > cmd.live) begin
            if (cell_id >= cmd.live && cell_id < cmd.nlen) slot_nxt = '0;
          end else begin
            if (cell_id >= cmd.nlen && cell_id < cmd.live) slot_nxt = csa_pkg::SLOT_ONES;
          end
        end
        csa_pkg::OP_WRITE: begin
          if (id_ext == cmd.idx) slot_nxt = cmd.wval;
        end
        default: begin
          slot_nxt = slot_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= csa_pkg::SLOT_ONES;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/compacting_slot_array.sv
// Top level of the compacting slot array: handshake, register port, live
// count and the row of slot cells. Depends on csa_pkg and csa_cell.
`default_nettype none

// A densely packed list of 64 slots of 32 bits with a live count, driven by
// one command beat at a time (clear, append, remove, resize, read, write).
// Each beat is applied at once: all slot cells update in parallel in the
// cycle the beat is accepted, remove shifting each cell from its upper
// neighbor, and the result is held in an output register. A new beat is taken
// while that register is empty or in the cycle its beat leaves, so a stalled
// result holds off the input. Reset fills every slot with ones; no clearing
// pass. max_count sits at byte address 0 and limits append and resize.
module compacting_slot_array (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [csa_pkg::OP_W-1:0]        in_opcode,
  input  wire logic [csa_pkg::INDEX_W-1:0]     in_slot_index,
  input  wire logic [csa_pkg::INDEX_W-1:0]     in_new_length,
  input  wire logic [31:0]                     in_write_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [csa_pkg::STATUS_W-1:0]    out_status,
  output logic      [csa_pkg::INDEX_W-1:0]     out_appended_index,
  output logic      [31:0]                     out_read_value,
  output logic      [csa_pkg::COUNT_W-1:0]     out_length_now,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  logic [csa_pkg::COUNT_W-1:0]   max_count_r;
  logic [csa_pkg::COUNT_W-1:0]   live_r;
  logic [csa_pkg::COUNT_W-1:0]   live_nxt;
  logic                          out_valid_r;
  logic [csa_pkg::STATUS_W-1:0]  status_r;
  logic [csa_pkg::STATUS_W-1:0]  status_nxt;
  logic [csa_pkg::INDEX_W-1:0]   app_idx_r;
  logic [csa_pkg::INDEX_W-1:0]   app_idx_nxt;
  logic [31:0]                   rd_r;
  logic [31:0]                   rd_nxt;
  logic [csa_pkg::COUNT_W-1:0]   lim;
  logic                          accept;
  logic                          op_ok;
  logic                          idx_live;
  logic                          cfg_wr;
  logic [csa_pkg::ELEM_BITS-1:0] rd_or;
  csa_pkg::cell_cmd_t            cmd;

  logic [csa_pkg::ELEM_BITS-1:0] slot_q  [csa_pkg::MAX_ENTRIES];
  logic [csa_pkg::ELEM_BITS-1:0] up_q    [csa_pkg::MAX_ENTRIES];
  logic [csa_pkg::ELEM_BITS-1:0] rd_part [csa_pkg::MAX_ENTRIES];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (int'(paddr[2]) == csa_pkg::REG_MAX_COUNT);
  assign prdata = (int'(paddr[2]) == csa_pkg::REG_MAX_COUNT) ? {25'd0, max_count_r} : 32'd0;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_status         = status_r;
  assign out_appended_index = app_idx_r;
  assign out_read_value     = rd_r;
  assign out_length_now     = live_r;

  assign lim      = (max_count_r > csa_pkg::ENTRY_LIMIT) ? csa_pkg::ENTRY_LIMIT : max_count_r;
  assign idx_live = in_slot_index < {1'b0, live_r};

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < csa_pkg::MAX_ENTRIES; i++) begin
      rd_or = rd_or | rd_part[i];
    end
  end

  always_comb begin
    op_ok       = 1'b1;
    status_nxt  = csa_pkg::ST_OK;
    app_idx_nxt = '0;
    rd_nxt      = '0;
    live_nxt    = live_r;
    unique case (in_opcode)
      csa_pkg::OP_CLEAR: begin
        live_nxt = '0;
      end
      csa_pkg::OP_APPEND: begin
        if (live_r < lim) begin
          app_idx_nxt = {1'b0, live_r};
          live_nxt    = live_r + 7'd1;
        end else begin
          op_ok      = 1'b0;
          status_nxt = csa_pkg::ST_FULL;
        end
      end
      csa_pkg::OP_REMOVE: begin
        if (idx_live) begin
          live_nxt = live_r - 7'd1;
        end else begin
          op_ok      = 1'b0;
          status_nxt = csa_pkg::ST_BAD_INDEX;
        end
      end
      csa_pkg::OP_RESIZE: begin
        if (in_new_length < {1'b0, lim}) begin
          live_nxt = in_new_length[csa_pkg::COUNT_W-1:0];
        end else begin
          op_ok      = 1'b0;
          status_nxt = csa_pkg::ST_BAD_LENGTH;
        end
      end
      csa_pkg::OP_READ: begin
        if (idx_live) begin
          rd_nxt = rd_or[31:0];
        end else begin
          op_ok      = 1'b0;
          status_nxt = csa_pkg::ST_BAD_INDEX;
        end
      end
      csa_pkg::OP_WRITE: begin
        if (!idx_live) begin
          op_ok      = 1'b0;
          status_nxt = csa_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.ok   = accept && op_ok;
    cmd.op   = in_opcode;
    cmd.idx  = in_slot_index;
    cmd.nlen = in_new_length[csa_pkg::COUNT_W-1:0];
    cmd.live = live_r;
    cmd.wval = in_write_value;
  end

  for (genvar g = 0; g < csa_pkg::MAX_ENTRIES; g++) begin : g_cell
    if (g == csa_pkg::MAX_ENTRIES - 1) begin : g_top
      assign up_q[g] = csa_pkg::SLOT_ONES;
    end else begin : g_mid
      assign up_q[g] = slot_q[g+1];
    end
    csa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (csa_pkg::COUNT_W'(g)),
      .cmd     (cmd),
      .up_slot (up_q[g]),
      .slot    (slot_q[g]),
      .rd_part (rd_part[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= csa_pkg::MAX_COUNT_RESET;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) max_count_r <= pwdata[csa_pkg::COUNT_W-1:0];
      if (accept) begin
        live_r      <= live_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      app_idx_r <= app_idx_nxt;
      rd_r      <= rd_nxt;
    end
  end

endmodule

`default_nettype wire
